// ===== design/msf_pkg.sv =====
// Shared types and constants for the multichannel sample FIFO.
package msf_pkg;

    // Width of the capacity configuration register.
    localparam int CFG_W = 11;
    // Capacity after reset, before clamping to the store depth.
    localparam int CAPACITY_RESET = 1024;
    // Width of the fill count reported with every result.
    localparam int COUNT_W = 11;

    // Command codes.
    localparam logic [0:0] CMD_PUSH = 1'b0;
    localparam logic [0:0] CMD_POP  = 1'b1;

    typedef struct packed {
        logic [0:0]  command;
        logic [2:0]  channel;
        logic [31:0] sample_in;
        logic        block_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        sample_out;
        logic [COUNT_W-1:0] fill_count;
        logic               overflow;
        logic               underflow;
        logic               block_last_out;
    } t_out_item;

    // Result flags of one transaction, produced by the channel controller.
    typedef struct packed {
        logic               pop_ok;
        logic               overflow;
        logic               underflow;
        logic               block_last;
        logic [COUNT_W-1:0] fill_count;
    } t_step_flags;

    // Sample store access for one cycle.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctl;

    // Read-index rebuild sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT
    } t_rebuild_state;

endpackage

// ===== design/msf_mod_unit.sv =====
// Iterative remainder unit: signed value modulo an unsigned divisor, one bit per cycle.
module msf_mod_unit #(
    parameter int MAG_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_neg,
    input  logic [MAG_W-1:0] i_mag,
    input  logic [MAG_W-1:0] i_div,
    output logic             o_done,
    output logic [MAG_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0] r_mag;
    logic [MAG_W:0]   r_rem;
    logic [MAG_W-1:0] r_div;
    logic             r_neg;

    logic [MAG_W:0]   n_trial;
    logic [MAG_W:0]   n_rem;

    // Restoring step: shift in the next dividend bit and subtract when possible.
    always_comb begin
        n_trial = {r_rem[MAG_W-1:0], r_mag[MAG_W-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_rem = n_trial - {1'b0, r_div};
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(MAG_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_rem <= '0;
            r_div <= i_div;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    // A negative value with a nonzero remainder folds back into the range.
    assign o_done = r_done;
    assign o_rem  = (r_neg && (r_rem != '0)) ? (r_div - r_rem[MAG_W-1:0])
                                             : r_rem[MAG_W-1:0];

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < r_div))
        else $error("remainder not below divisor");

endmodule

// ===== design/msf_store.sv =====
// Shared sample store: one write port and one registered read port.
module msf_store #(
    parameter int WORD_W = 32,
    parameter int WORDS  = 8192
) (
    input  logic                     i_clk,
    input  msf_pkg::t_store_ctl      i_ctl,
    input  logic [$clog2(WORDS)-1:0] i_addr,
    input  logic [WORD_W-1:0]        i_wdata,
    output logic [WORD_W-1:0]        o_rdata
);
    import msf_pkg::*;

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/msf_chan_ctrl.sv =====
// Per-channel pointers and fill levels, transaction decision and read-index rebuild.
module msf_chan_ctrl #(
    parameter int CHANNELS = 8,
    parameter int DEPTH    = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [$clog2(DEPTH+1)-1:0]            i_cap,
    input  logic                                  i_rebuild,
    input  logic                                  i_item_valid,
    input  msf_pkg::t_in_item                     i_item,
    output msf_pkg::t_store_ctl                   o_store,
    output logic [$clog2(CHANNELS*DEPTH)-1:0]     o_addr,
    output msf_pkg::t_step_flags                  o_flags,
    output logic                                  o_busy
);
    import msf_pkg::*;

    localparam int CAP_W  = $clog2(DEPTH + 1);
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = $clog2(CHANNELS * DEPTH);

    logic [PTR_W-1:0] r_wp  [CHANNELS];
    logic [CAP_W-1:0] r_lvl [CHANNELS];
    // Oldest-sample slot, kept equal to (write pointer - fill level) mod capacity.
    logic [PTR_W-1:0] r_rd  [CHANNELS];

    t_rebuild_state r_state;
    t_rebuild_state n_state;
    logic [CH_W-1:0] r_ch;

    logic             in_range;
    logic [CH_W-1:0]  ch;
    logic [PTR_W-1:0] wp;
    logic [CAP_W-1:0] lvl;
    logic [PTR_W-1:0] rd;
    logic             wp_wrap;
    logic [PTR_W-1:0] idx;
    logic [CAP_W-1:0] inc;
    logic [PTR_W-1:0] wp_nxt;
    logic [CAP_W-1:0] rd_inc;
    logic [PTR_W-1:0] rd_pop;
    logic [PTR_W-1:0] rd_push;
    logic             is_pop;
    logic             full;
    logic             empty;
    logic             do_push;
    logic             do_pop;
    logic [CAP_W-1:0] lvl_new;

    logic             last_ch;
    logic [CAP_W-1:0] rb_wp;
    logic [CAP_W-1:0] rb_lvl;
    logic             rb_neg;
    logic [CAP_W-1:0] rb_mag;
    logic             mod_start;
    logic             mod_done;
    logic [CAP_W-1:0] mod_rem;
    logic             rb_write;

    always_comb begin
        in_range = 32'(i_item.channel) < CHANNELS;
        ch       = CH_W'(i_item.channel);
        wp       = r_wp[ch];
        lvl      = r_lvl[ch];
        rd       = r_rd[ch];
        is_pop   = i_item.command == CMD_POP;
        full     = lvl >= i_cap;
        empty    = lvl == '0;

        // A pointer left beyond a reduced capacity restarts at slot zero.
        wp_wrap = CAP_W'(wp) >= i_cap;
        idx     = wp_wrap ? '0 : wp;
        inc     = CAP_W'(idx) + CAP_W'(1);
        wp_nxt  = (inc >= i_cap) ? '0 : PTR_W'(inc);

        rd_inc  = CAP_W'(rd) + CAP_W'(1);
        rd_pop  = (rd_inc >= i_cap) ? '0 : PTR_W'(rd_inc);
        // After a restart at slot zero the oldest slot is -level mod capacity.
        rd_push = wp_wrap ? (empty ? '0 : PTR_W'(i_cap - lvl)) : rd;

        do_push = i_item_valid && in_range && !is_pop && !full;
        do_pop  = i_item_valid && in_range && is_pop && !empty;

        if (do_push) begin
            lvl_new = lvl + CAP_W'(1);
        end else if (do_pop) begin
            lvl_new = lvl - CAP_W'(1);
        end else begin
            lvl_new = lvl;
        end

        o_addr = ADDR_W'(ch) * ADDR_W'(DEPTH) + ADDR_W'(is_pop ? rd : idx);
        o_store.wr_en = do_push;
        o_store.rd_en = do_pop;

        o_flags.pop_ok     = do_pop;
        o_flags.overflow   = in_range && !is_pop && full;
        o_flags.underflow  = in_range && is_pop && empty;
        o_flags.block_last = i_item.block_last;
        o_flags.fill_count = in_range ? COUNT_W'(lvl_new) : '0;
    end

    // Rebuild operands: the signed difference of pointer and level for r_ch.
    always_comb begin
        rb_wp   = CAP_W'(r_wp[r_ch]);
        rb_lvl  = r_lvl[r_ch];
        rb_neg  = rb_lvl > rb_wp;
        rb_mag  = rb_neg ? (rb_lvl - rb_wp) : (rb_wp - rb_lvl);
        last_ch = r_ch == CH_W'(CHANNELS - 1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: n_state = ST_IDLE;
            ST_LOAD: n_state = ST_WAIT;
            ST_WAIT: begin
                if (mod_done) begin
                    n_state = last_ch ? ST_IDLE : ST_LOAD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_rebuild) begin
            n_state = ST_LOAD;
        end
    end

    always_comb begin
        mod_start = (r_state == ST_LOAD) && !i_rebuild;
        rb_write  = (r_state == ST_WAIT) && mod_done && !i_rebuild;
        o_busy    = (r_state != ST_IDLE) || i_rebuild;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (i_rebuild) begin
                r_ch <= '0;
            end else if (rb_write && !last_ch) begin
                r_ch <= r_ch + CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_wp[i]  <= '0;
                r_lvl[i] <= '0;
                r_rd[i]  <= '0;
            end
        end else begin
            if (do_push) begin
                r_wp[ch]  <= wp_nxt;
                r_lvl[ch] <= lvl_new;
                r_rd[ch]  <= rd_push;
            end else if (do_pop) begin
                r_lvl[ch] <= lvl_new;
                r_rd[ch]  <= rd_pop;
            end
            if (rb_write) begin
                r_rd[r_ch] <= PTR_W'(mod_rem);
            end
        end
    end

    msf_mod_unit #(
        .MAG_W (CAP_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_neg   (rb_neg),
        .i_mag   (rb_mag),
        .i_div   (i_cap),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    a_rebuild_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rb_write && last_ch && !i_rebuild) |=> (r_state == ST_IDLE) || $past(i_rebuild))
        else $error("rebuild did not finish after the last channel");

endmodule

// ===== design/multichannel_sample_fifo_top.sv =====
// Top level of the multichannel sample FIFO.
//
// A bank of CHANNELS circular sample FIFOs that share one store of
// CHANNELS*DEPTH words. A transaction is offered on i_item with start and is
// accepted at a clock edge where start is high and busy is low. A push stores
// sample_in in the channel's FIFO; a pop returns its oldest sample. A push into
// a full channel is dropped and flagged as overflow, and a pop from an empty
// channel returns zero and is flagged as underflow. Every transaction reports
// the channel's fill count after it, and block_last is echoed.
//
// Each accepted transaction gives exactly one result on o_result, marked by o_valid
// for one cycle, through the input and result registers. While busy is low, one
// transaction can be accepted every cycle; the store's single write and single registered
// read port serve one transaction per cycle. The receiver cannot stall results.
//
// A write to the capacity register (i_cfg_we, i_cfg_wdata) recomputes every
// channel's read slot with a bit-serial remainder unit. Busy is high from the
// write cycle until the last channel's read slot has been rewritten. Reset
// empties every channel and sets the capacity to 1024, clamped to DEPTH;
// stored samples are not cleared.
module multichannel_sample_fifo_top #(
    parameter int CHANNELS    = 8,
    parameter int DEPTH       = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  msf_pkg::t_in_item              i_item,
    input  logic                           i_cfg_we,
    input  logic [msf_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                           o_valid,
    output msf_pkg::t_out_item             o_result
);
    import msf_pkg::*;

    localparam int CAP_W     = $clog2(DEPTH + 1);
    localparam int ADDR_W    = $clog2(CHANNELS * DEPTH);
    localparam int CAP_RESET = (DEPTH < CAPACITY_RESET) ? DEPTH : CAPACITY_RESET;

    // Capacity is held already clamped to the range 1 to DEPTH.
    logic [CAP_W-1:0]       r_cap;
    logic [CAP_W-1:0]       n_cap;

    // Input register of the single processing pass.
    logic                   r_in_valid;
    t_in_item               r_in;

    // Result register; the sample comes from the store's read register.
    logic                   r_res_valid;
    t_step_flags            r_flags;

    t_store_ctl             store_ctl;
    logic [ADDR_W-1:0]      store_addr;
    logic [SAMPLE_BITS-1:0] store_rdata;
    t_step_flags            flags;
    logic                   ctrl_busy;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cap = CAP_W'(1);
        end else if (32'(i_cfg_wdata) > DEPTH) begin
            n_cap = CAP_W'(DEPTH);
        end else begin
            n_cap = CAP_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_W'(CAP_RESET);
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
            r_in_valid  <= start && !busy;
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_flags <= flags;
        end
    end

    msf_chan_ctrl #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cap        (r_cap),
        .i_rebuild    (i_cfg_we),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .o_store      (store_ctl),
        .o_addr       (store_addr),
        .o_flags      (flags),
        .o_busy       (ctrl_busy)
    );

    msf_store #(
        .WORD_W (SAMPLE_BITS),
        .WORDS  (CHANNELS * DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (store_ctl),
        .i_addr  (store_addr),
        .i_wdata (SAMPLE_BITS'(r_in.sample_in)),
        .o_rdata (store_rdata)
    );

    assign busy    = ctrl_busy;
    assign o_valid = r_res_valid;

    // Pushes, underflows and ignored channels report a zero sample.
    always_comb begin
        o_result.sample_out     = r_flags.pop_ok ? 32'(store_rdata) : '0;
        o_result.fill_count     = r_flags.fill_count;
        o_result.overflow       = r_flags.overflow;
        o_result.underflow      = r_flags.underflow;
        o_result.block_last_out = r_flags.block_last;
    end

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted transaction produced no result");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.underflow) |->
            (o_result.sample_out == '0) && (o_result.fill_count == '0))
        else $error("underflow result carries data or a count");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("capacity write did not start the rebuild pass");

endmodule
